[sv/rcpwc_pkg.sv]
`timescale 1ns / 1ps

package rcpwc_pkg;

	localparam int LEVEL_W = 8;
	localparam int TIME_W  = 32;
	localparam int CH_W    = 3;
	localparam int WIDTH_W = 16;
	localparam int GAP_W   = 24;
	localparam int CFG_W   = 24;
	localparam int IDX_W   = 3;

	typedef enum logic [IDX_W-1:0] {
		CFG_ENABLE   = 3'd0,
		CFG_MIN_HIGH = 3'd1,
		CFG_MAX_HIGH = 3'd2,
		CFG_MIN_LOW  = 3'd3,
		CFG_MAX_LOW  = 3'd4
	} cfg_idx_t;

	localparam logic [LEVEL_W-1:0] ENABLE_RST   = 8'h3F;
	localparam logic [WIDTH_W-1:0] MIN_HIGH_RST = 16'd950;
	localparam logic [WIDTH_W-1:0] MAX_HIGH_RST = 16'd2075;
	localparam logic [GAP_W-1:0]   MIN_LOW_RST  = 24'd12000;
	localparam logic [GAP_W-1:0]   MAX_LOW_RST  = 24'd24000;

	typedef struct packed {
		logic [LEVEL_W-1:0] enable;
		logic [WIDTH_W-1:0] min_high;
		logic [WIDTH_W-1:0] max_high;
		logic [GAP_W-1:0]   min_low;
		logic [GAP_W-1:0]   max_low;
	} cfg_t;

endpackage

[sv/rcpwc_in_if.sv]
`timescale 1ns / 1ps

interface rcpwc_in_if;
	logic                        valid;
	logic                        ready;
	logic [rcpwc_pkg::LEVEL_W-1:0] pin_levels;
	logic [rcpwc_pkg::TIME_W-1:0]  time_us;

	modport source (output valid, output pin_levels, output time_us, input ready);
	modport sink (input valid, input pin_levels, input time_us, output ready);
endinterface

[sv/rcpwc_out_if.sv]
`timescale 1ns / 1ps

interface rcpwc_out_if;
	logic                          valid;
	logic                          ready;
	logic [rcpwc_pkg::CH_W-1:0]    channel;
	logic [rcpwc_pkg::WIDTH_W-1:0] pulse_width;
	logic                          last_of_run;

	modport source (output valid, output channel, output pulse_width, output last_of_run,
		input ready);
	modport sink (input valid, input channel, input pulse_width, input last_of_run,
		output ready);
endinterface

[sv/rc_pwm_pulse_width_capture_top.sv]
`timescale 1ns / 1ps

// A sample beat is registered in the input stage, evaluated there, and its captures are
// loaded into the capture register, from which they are offered. Throughput: one sample per
// cycle while each sample completes at most one pulse and the receiver is ready; a sample
// completing more than one pulse holds the input until the single result port has drained the
// capture register, one channel per cycle while the receiver is ready.
// Reset clears the level history, armed bits, stored times and queues, and loads the default configuration.
module rc_pwm_pulse_width_capture_top #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rcpwc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [rcpwc_pkg::CFG_W-1:0]     cfg_data,
	rcpwc_in_if.sink                        smp,
	rcpwc_out_if.source                     cap
);

	localparam int NCH = (NUM_CHANNELS < rcpwc_pkg::LEVEL_W) ? NUM_CHANNELS
		: rcpwc_pkg::LEVEL_W;

	rcpwc_pkg::cfg_t cfg_q;

	logic                              valid_s1;
	logic [rcpwc_pkg::LEVEL_W-1:0]     lev_s1;
	logic [rcpwc_pkg::TIME_W-1:0]      time_s1;

	logic [rcpwc_pkg::LEVEL_W-1:0]     prev_q;
	logic [NCH-1:0]                    armed_q;
	logic [rcpwc_pkg::TIME_W-1:0]      rise_q [NCH];
	logic [rcpwc_pkg::TIME_W-1:0]      fall_q [NCH];

	logic [NCH-1:0]                    pend_s2;
	logic [rcpwc_pkg::WIDTH_W-1:0]     width_s2 [NCH];

	logic [rcpwc_pkg::LEVEL_W-1:0]     changed;
	logic [NCH-1:0]                    cap_mask;
	logic [NCH-1:0]                    low_ok;
	logic [rcpwc_pkg::TIME_W-1:0]      dt_high [NCH];
	logic [NCH-1:0]                    low_oh;
	logic [NCH-1:0]                    pend_rest;
	logic                              s2_free;
	logic                              adv;
	logic                              out_hs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable   <= rcpwc_pkg::ENABLE_RST;
			cfg_q.min_high <= rcpwc_pkg::MIN_HIGH_RST;
			cfg_q.max_high <= rcpwc_pkg::MAX_HIGH_RST;
			cfg_q.min_low  <= rcpwc_pkg::MIN_LOW_RST;
			cfg_q.max_low  <= rcpwc_pkg::MAX_LOW_RST;
		end else if (cfg_we) begin
			case (rcpwc_pkg::cfg_idx_t'(cfg_index))
				rcpwc_pkg::CFG_ENABLE:   cfg_q.enable   <= cfg_data[rcpwc_pkg::LEVEL_W-1:0];
				rcpwc_pkg::CFG_MIN_HIGH: cfg_q.min_high <= cfg_data[rcpwc_pkg::WIDTH_W-1:0];
				rcpwc_pkg::CFG_MAX_HIGH: cfg_q.max_high <= cfg_data[rcpwc_pkg::WIDTH_W-1:0];
				rcpwc_pkg::CFG_MIN_LOW:  cfg_q.min_low  <= cfg_data[rcpwc_pkg::GAP_W-1:0];
				rcpwc_pkg::CFG_MAX_LOW:  cfg_q.max_low  <= cfg_data[rcpwc_pkg::GAP_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_hs    = cap.valid && cap.ready;
	assign s2_free   = (pend_s2 == '0) || (out_hs && (pend_rest == '0));
	assign adv       = valid_s1 && s2_free;
	assign smp.ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (smp.ready) begin
			valid_s1 <= smp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (smp.ready && smp.valid) begin
			lev_s1  <= smp.pin_levels;
			time_s1 <= smp.time_us;
		end
	end

	assign changed = (lev_s1 ^ prev_q) & cfg_q.enable;

	always_comb begin
		logic [rcpwc_pkg::TIME_W-1:0] dt_low;
		for (int k = 0; k < NCH; k++) begin
			dt_low     = time_s1 - fall_q[k];
			dt_high[k] = time_s1 - rise_q[k];
			low_ok[k]  = (dt_low >= rcpwc_pkg::TIME_W'(cfg_q.min_low))
				&& (dt_low <= rcpwc_pkg::TIME_W'(cfg_q.max_low));
			cap_mask[k] = changed[k] && !lev_s1[k] && armed_q[k]
				&& (dt_high[k] >= rcpwc_pkg::TIME_W'(cfg_q.min_high))
				&& (dt_high[k] <= rcpwc_pkg::TIME_W'(cfg_q.max_high));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			armed_q <= '0;
			for (int k = 0; k < NCH; k++) begin
				rise_q[k] <= '0;
				fall_q[k] <= '0;
			end
		end else if (adv) begin
			prev_q <= lev_s1;
			for (int k = 0; k < NCH; k++) begin
				if (changed[k]) begin
					if (lev_s1[k]) begin
						rise_q[k]  <= time_s1;
						armed_q[k] <= low_ok[k];
					end else begin
						fall_q[k] <= time_s1;
						if (cap_mask[k]) begin
							armed_q[k] <= 1'b0;
						end
					end
				end
			end
		end
	end

	assign low_oh    = pend_s2 & (~pend_s2 + NCH'(1));
	assign pend_rest = pend_s2 & ~low_oh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
		end else if (adv) begin
			pend_s2 <= cap_mask;
		end else if (out_hs) begin
			pend_s2 <= pend_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NCH; k++) begin
				width_s2[k] <= dt_high[k][rcpwc_pkg::WIDTH_W-1:0];
			end
		end
	end

	always_comb begin
		cap.channel     = '0;
		cap.pulse_width = '0;
		for (int k = 0; k < NCH; k++) begin
			if (low_oh[k]) begin
				cap.channel     = cap.channel | rcpwc_pkg::CH_W'(k);
				cap.pulse_width = cap.pulse_width | width_s2[k];
			end
		end
	end

	assign cap.valid       = (pend_s2 != '0);
	assign cap.last_of_run = (pend_rest == '0);

	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs && !cap.last_of_run |=> cap.valid)
		else $error("capture run ended before its last beat");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs && !cap.last_of_run |=> cap.channel > $past(cap.channel))
		else $error("captures of one sample left out of channel order");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!smp.ready |-> valid_s1 && (pend_s2 != '0))
		else $error("input stalled without a pending sample and capture");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> pend_s2 == $past(cap_mask))
		else $error("capture register not loaded from the evaluated sample");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam int NCH        = 8;
	localparam int HOLD_LEN   = 150;
	localparam int IDLE_LIMIT = 4000;

	typedef struct packed {
		logic [rcpwc_pkg::LEVEL_W-1:0] levels;
		logic [rcpwc_pkg::TIME_W-1:0]  stamp;
	} sample_t;

	typedef struct packed {
		logic [rcpwc_pkg::CH_W-1:0]    channel;
		logic [rcpwc_pkg::WIDTH_W-1:0] width;
		logic                          last;
	} capture_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [rcpwc_pkg::IDX_W-1:0]   cfg_index;
	logic [rcpwc_pkg::CFG_W-1:0]   cfg_data;

	rcpwc_in_if  smp_bus ();
	rcpwc_out_if cap_bus ();

	rc_pwm_pulse_width_capture_top #(
		.NUM_CHANNELS(NCH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.smp       (smp_bus),
		.cap       (cap_bus)
	);

	always #5 clk = ~clk;

	// Shadow of the block's configuration and per-channel timing state.
	rcpwc_pkg::cfg_t               model_cfg;
	logic [rcpwc_pkg::LEVEL_W-1:0] lvl_hist;
	logic                          ch_armed [NCH];
	logic [rcpwc_pkg::TIME_W-1:0]  rise_at [NCH];
	logic [rcpwc_pkg::TIME_W-1:0]  fall_at [NCH];

	sample_t            sample_queue [$];
	capture_t           pending_captures [$];
	sample_t            next_sample;
	capture_t           got_cap;
	capture_t           want_cap;

	int                 error_count   = 0;
	int                 captures_seen = 0;
	int                 items_queued  = 0;
	int                 hold_req      = 0;
	int                 hold_seen     = 0;
	int                 hold_left     = 0;
	int                 idle_cycles   = 0;
	int                 tx_wait, tx_stretch, rx_wait, rx_stretch;
	bit                 tx_quiet, rx_quiet;
	logic [rcpwc_pkg::TIME_W-1:0] stim_clock;

	task automatic predict_captures(input logic [rcpwc_pkg::LEVEL_W-1:0] levels,
		input logic [rcpwc_pkg::TIME_W-1:0] stamp);
		logic [rcpwc_pkg::LEVEL_W-1:0] edges;
		logic [rcpwc_pkg::TIME_W-1:0]  dt;
		capture_t           found [$];
		capture_t           c;
		edges = (levels ^ lvl_hist) & model_cfg.enable;
		lvl_hist = levels;
		for (int ch = 0; ch < NCH; ch++) begin
			if (edges[ch]) begin
				if (levels[ch]) begin
					dt = stamp - fall_at[ch];
					rise_at[ch] = stamp;
					ch_armed[ch] = (dt >= model_cfg.min_low) && (dt <= model_cfg.max_low);
				end else begin
					dt = stamp - rise_at[ch];
					fall_at[ch] = stamp;
					if (ch_armed[ch] && dt >= model_cfg.min_high && dt <= model_cfg.max_high) begin
						ch_armed[ch] = 1'b0;
						c.channel = rcpwc_pkg::CH_W'(ch);
						c.width = dt[rcpwc_pkg::WIDTH_W-1:0];
						c.last = 1'b0;
						found.push_back(c);
					end
				end
			end
		end
		if (found.size() > 0)
			found[found.size()-1].last = 1'b1;
		foreach (found[i])
			pending_captures.push_back(found[i]);
	endtask

	task automatic log_mismatch(input string what, input capture_t want, input capture_t got);
		error_count++;
		if (error_count <= 10)
			$display("%s: expected ch %0d width %0d last %0d, got ch %0d width %0d last %0d",
				what, want.channel, want.width, want.last, got.channel, got.width, got.last);
	endtask

	task automatic cfg_write(input logic [rcpwc_pkg::IDX_W-1:0] idx,
		input logic [rcpwc_pkg::CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			rcpwc_pkg::CFG_ENABLE:   model_cfg.enable = data[rcpwc_pkg::LEVEL_W-1:0];
			rcpwc_pkg::CFG_MIN_HIGH: model_cfg.min_high = data[rcpwc_pkg::WIDTH_W-1:0];
			rcpwc_pkg::CFG_MAX_HIGH: model_cfg.max_high = data[rcpwc_pkg::WIDTH_W-1:0];
			rcpwc_pkg::CFG_MIN_LOW:  model_cfg.min_low = data[rcpwc_pkg::GAP_W-1:0];
			rcpwc_pkg::CFG_MAX_LOW:  model_cfg.max_low = data[rcpwc_pkg::GAP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic cfg_done();
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (sample_queue.size() != 0 || smp_bus.valid || pending_captures.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic push_sample(input logic [rcpwc_pkg::LEVEL_W-1:0] levels,
		input logic [rcpwc_pkg::TIME_W-1:0] stamp);
		sample_t s;
		s.levels = levels;
		s.stamp = stamp;
		sample_queue.push_back(s);
		items_queued++;
	endtask

	// One servo frame: a low gap, a rising edge on a set of pins, then the falls in order of
	// their pulse widths, pins with equal widths falling in the same sample; now and then a stray random sample follows.
	task automatic push_frame(input bit full_set);
		logic [rcpwc_pkg::LEVEL_W-1:0] lv;
		logic [rcpwc_pkg::TIME_W-1:0]  t0, gap;
		logic [rcpwc_pkg::WIDTH_W-1:0] w [NCH];
		logic [rcpwc_pkg::WIDTH_W-1:0] wmin, wlast;
		bit                 same;
		if ($urandom_range(9, 0) < 8 && model_cfg.min_low <= model_cfg.max_low)
			gap = $urandom_range(model_cfg.max_low, model_cfg.min_low);
		else
			gap = $urandom_range(40000, 0);
		t0 = stim_clock + gap;
		lv = full_set ? 8'hFF : rcpwc_pkg::LEVEL_W'($urandom());
		push_sample(lv, t0);
		same = ($urandom_range(3, 0) == 0);
		for (int ch = 0; ch < NCH; ch++) begin
			if (same && ch > 0)
				w[ch] = w[0];
			else if ($urandom_range(9, 0) < 8 && model_cfg.min_high <= model_cfg.max_high)
				w[ch] = rcpwc_pkg::WIDTH_W'($urandom_range(model_cfg.max_high,
					model_cfg.min_high));
			else
				w[ch] = rcpwc_pkg::WIDTH_W'($urandom_range(4000, 0));
		end
		wlast = '0;
		while (lv != '0) begin
			wmin = '1;
			for (int ch = 0; ch < NCH; ch++)
				if (lv[ch] && w[ch] <= wmin)
					wmin = w[ch];
			for (int ch = 0; ch < NCH; ch++)
				if (lv[ch] && w[ch] == wmin)
					lv[ch] = 1'b0;
			push_sample(lv, t0 + wmin);
			wlast = wmin;
		end
		if ($urandom_range(5, 0) == 0)
			push_sample(rcpwc_pkg::LEVEL_W'($urandom()), $urandom());
		stim_clock = t0 + wlast;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_bus.valid <= 1'b0;
			smp_bus.pin_levels <= '0;
			smp_bus.time_us <= '0;
			tx_wait = 0;
			tx_stretch = 0;
			tx_quiet = 1'b0;
		end else begin
			if (smp_bus.valid && smp_bus.ready)
				predict_captures(smp_bus.pin_levels, smp_bus.time_us);
			if (!smp_bus.valid || smp_bus.ready) begin
				if (tx_wait > 0) begin
					tx_wait--;
					smp_bus.valid <= 1'b0;
				end else if (sample_queue.size() > 0) begin
					next_sample = sample_queue.pop_front();
					smp_bus.valid <= 1'b1;
					smp_bus.pin_levels <= next_sample.levels;
					smp_bus.time_us <= next_sample.stamp;
					if (tx_stretch == 0) begin
						tx_stretch = $urandom_range(24, 6);
						tx_quiet = ($urandom_range(3, 0) == 0);
					end
					tx_stretch--;
					tx_wait = tx_quiet ? 0 : $urandom_range(7, 0);
				end else begin
					smp_bus.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_bus.ready <= 1'b0;
			rx_wait = 0;
			rx_stretch = 0;
			rx_quiet = 1'b0;
		end else begin
			if (cap_bus.valid && cap_bus.ready) begin
				captures_seen++;
				got_cap.channel = cap_bus.channel;
				got_cap.width = cap_bus.pulse_width;
				got_cap.last = cap_bus.last_of_run;
				if (pending_captures.size() == 0) begin
					log_mismatch("unexpected capture", '0, got_cap);
				end else begin
					want_cap = pending_captures.pop_front();
					if (got_cap.channel !== want_cap.channel || got_cap.width !== want_cap.width
						|| got_cap.last !== want_cap.last)
						log_mismatch("capture mismatch", want_cap, got_cap);
				end
				if (rx_stretch == 0) begin
					rx_stretch = $urandom_range(24, 6);
					rx_quiet = ($urandom_range(3, 0) == 0);
				end
				rx_stretch--;
				rx_wait = rx_quiet ? 0 : $urandom_range(7, 0);
			end
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				cap_bus.ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				cap_bus.ready <= 1'b0;
			end else begin
				cap_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((smp_bus.valid && smp_bus.ready) || (cap_bus.valid && cap_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	initial begin
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n = 1'b0;
		model_cfg.enable = rcpwc_pkg::ENABLE_RST;
		model_cfg.min_high = rcpwc_pkg::MIN_HIGH_RST;
		model_cfg.max_high = rcpwc_pkg::MAX_HIGH_RST;
		model_cfg.min_low = rcpwc_pkg::MIN_LOW_RST;
		model_cfg.max_low = rcpwc_pkg::MAX_LOW_RST;
		lvl_hist = '0;
		for (int ch = 0; ch < NCH; ch++) begin
			ch_armed[ch] = 1'b0;
			rise_at[ch] = '0;
			fall_at[ch] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Window boundaries, several captures in one beat, rejected falls, a disarmed
		// channel, disabled pins and a pulse that straddles the timestamp wrap.
		push_sample(8'h00, 32'd0);
		push_sample(8'hFF, 32'd12000);
		push_sample(8'hFE, 32'd12950);
		push_sample(8'hF8, 32'd14075);
		push_sample(8'hF0, 32'd14076);
		push_sample(8'hC0, 32'd12949);
		push_sample(8'hC8, 32'd38076);
		push_sample(8'hC0, 32'd39576);
		push_sample(8'hC1, 32'd40000);
		push_sample(8'hC0, 32'd41000);
		push_sample(8'hC4, 32'hFFFF_8000);
		push_sample(8'hC0, 32'hFFFF_C000);
		push_sample(8'hC4, 32'hFFFF_C000 + 32'd15500);
		push_sample(8'hC0, 32'hFFFF_C000 + 32'd16700);
		push_sample(8'h00, 32'hFFFF_FFFF);
		wait_drained();

		// Widest windows, every pin enabled, writes to the unused indices; the receiver holds off while full frames arrive.
		cfg_write(rcpwc_pkg::CFG_ENABLE, 24'h0000FF);
		cfg_write(rcpwc_pkg::CFG_MIN_HIGH, 24'h000000);
		cfg_write(rcpwc_pkg::CFG_MAX_HIGH, 24'hFFFFFF);
		cfg_write(rcpwc_pkg::CFG_MIN_LOW, 24'h000000);
		cfg_write(rcpwc_pkg::CFG_MAX_LOW, 24'hFFFFFF);
		for (int k = 1; k <= 3; k++)
			cfg_write(rcpwc_pkg::IDX_W'(rcpwc_pkg::CFG_MAX_LOW) + rcpwc_pkg::IDX_W'(k),
				rcpwc_pkg::CFG_W'($urandom()));
		cfg_done();
		hold_req++;
		stim_clock = $urandom();
		while (items_queued < 45)
			push_frame(1'b1);
		wait_drained();

		// Typical servo windows with a random mask; the sender pauses halfway for a full drain.
		cfg_write(rcpwc_pkg::CFG_ENABLE, rcpwc_pkg::CFG_W'($urandom_range(255, 0)));
		cfg_write(rcpwc_pkg::CFG_MIN_HIGH, rcpwc_pkg::CFG_W'($urandom_range(1000, 800)));
		cfg_write(rcpwc_pkg::CFG_MAX_HIGH, rcpwc_pkg::CFG_W'($urandom_range(2200, 1800)));
		cfg_write(rcpwc_pkg::CFG_MIN_LOW, rcpwc_pkg::CFG_W'($urandom_range(4000, 2000)));
		cfg_write(rcpwc_pkg::CFG_MAX_LOW, rcpwc_pkg::CFG_W'($urandom_range(30000, 20000)));
		cfg_done();
		while (items_queued < 60)
			push_frame(1'b0);
		wait_drained();
		while (items_queued < 75)
			push_frame(1'b0);
		wait_drained();

		// Both windows inverted, timestamps close to the wrap.
		cfg_write(rcpwc_pkg::CFG_ENABLE, 24'h0000FF);
		cfg_write(rcpwc_pkg::CFG_MIN_HIGH, 24'd2000);
		cfg_write(rcpwc_pkg::CFG_MAX_HIGH, 24'd1000);
		cfg_write(rcpwc_pkg::CFG_MIN_LOW, 24'd30000);
		cfg_write(rcpwc_pkg::CFG_MAX_LOW, 24'd100);
		cfg_done();
		stim_clock = 32'hFFFF_8000;
		while (items_queued < 85)
			push_frame(1'b0);
		wait_drained();

		// Every pin masked off: only the level history moves.
		cfg_write(rcpwc_pkg::CFG_ENABLE, 24'h000000);
		cfg_write(rcpwc_pkg::CFG_MIN_HIGH, 24'd900);
		cfg_write(rcpwc_pkg::CFG_MAX_HIGH, 24'd2100);
		cfg_write(rcpwc_pkg::CFG_MIN_LOW, 24'd5000);
		cfg_write(rcpwc_pkg::CFG_MAX_LOW, 24'd25000);
		cfg_done();
		while (items_queued < 95)
			push_frame(1'b0);
		wait_drained();

		// A single accepted width and an open-ended low gap.
		cfg_write(rcpwc_pkg::CFG_ENABLE, 24'h0000FF);
		cfg_write(rcpwc_pkg::CFG_MIN_HIGH, 24'd1500);
		cfg_write(rcpwc_pkg::CFG_MAX_HIGH, 24'd1500);
		cfg_write(rcpwc_pkg::CFG_MIN_LOW, 24'd5000);
		cfg_write(rcpwc_pkg::CFG_MAX_LOW, 24'hFFFFFF);
		cfg_done();
		stim_clock = 32'hFFFF_F000;
		while (items_queued < 105)
			push_frame(1'b0);
		wait_drained();

		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_captures.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
